### hw/rtl/dlts_pkg.sv
// Shared types and constants for the DFA token scanner.
// No dependencies; every other file of the block imports this package.
package dlts_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } src_word_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [15:0] token_start;
    logic [7:0]  token_length;
    logic        length_clipped;
    logic        run_last;
  } tok_word_t;

  // Everything one character produces: one token, or two when end of input flushes.
  typedef struct packed {
    tok_word_t first;
    tok_word_t second;
    logic      has_second;
  } tok_pair_t;

  typedef enum logic [3:0] {
    S_INIT   = 4'd0,
    S_ID     = 4'd1,
    S_I1     = 4'd2,
    S_I2     = 4'd3,
    S_I3     = 4'd4,
    S_LIT    = 4'd5,
    S_GT     = 4'd6,
    S_GE     = 4'd7,
    S_PLUS   = 4'd8,
    S_MINUS  = 4'd9,
    S_STAR   = 4'd10,
    S_SLASH  = 4'd11,
    S_SEMI   = 4'd12,
    S_LP     = 4'd13,
    S_RP     = 4'd14,
    S_ASSIGN = 4'd15
  } scan_state_t;

  localparam logic [3:0] KIND_IDENT  = 4'd0;
  localparam logic [3:0] KIND_INT    = 4'd1;
  localparam logic [3:0] KIND_INTLIT = 4'd2;
  localparam logic [3:0] KIND_GT     = 4'd3;
  localparam logic [3:0] KIND_GE     = 4'd4;
  localparam logic [3:0] KIND_PLUS   = 4'd5;
  localparam logic [3:0] KIND_MINUS  = 4'd6;
  localparam logic [3:0] KIND_STAR   = 4'd7;
  localparam logic [3:0] KIND_SLASH  = 4'd8;
  localparam logic [3:0] KIND_SEMI   = 4'd9;
  localparam logic [3:0] KIND_LPAREN = 4'd10;
  localparam logic [3:0] KIND_RPAREN = 4'd11;
  localparam logic [3:0] KIND_ASSIGN = 4'd12;

  localparam logic [7:0] CH_I      = 8'h69;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = 2;

  function automatic logic [3:0] kind_of_state(input scan_state_t s);
    logic [3:0] k;
    unique case (s)
      S_INIT, S_ID, S_I1, S_I2: k = KIND_IDENT;
      S_I3:     k = KIND_INT;
      S_LIT:    k = KIND_INTLIT;
      S_GT:     k = KIND_GT;
      S_GE:     k = KIND_GE;
      S_PLUS:   k = KIND_PLUS;
      S_MINUS:  k = KIND_MINUS;
      S_STAR:   k = KIND_STAR;
      S_SLASH:  k = KIND_SLASH;
      S_SEMI:   k = KIND_SEMI;
      S_LP:     k = KIND_LPAREN;
      S_RP:     k = KIND_RPAREN;
      S_ASSIGN: k = KIND_ASSIGN;
      default:  k = KIND_IDENT;
    endcase
    return k;
  endfunction

endpackage

### hw/rtl/dlts_front.sv
// Front end of the token scanner: character decode and the DFA state.
// Depends on dlts_pkg; writes one tok_pair_t per token-producing character.
module dlts_front #(
  parameter int POSITION_BITS = 16,
  parameter int MAX_TOKEN_LEN = 255
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                src_valid,
  output logic                src_stall,
  input  dlts_pkg::src_word_t src_data,
  input  logic                queue_full,
  output logic                push,
  output dlts_pkg::tok_pair_t push_data
);
  import dlts_pkg::*;

  localparam int LEN_BITS = $clog2(MAX_TOKEN_LEN + 1);

  scan_state_t          scan_state, scan_state_next;
  logic [POSITION_BITS-1:0] start_pos, start_pos_next;
  logic [POSITION_BITS-1:0] char_pos;
  logic [LEN_BITS-1:0]  run_len, run_len_next;
  logic                 overflowed, overflowed_next;

  logic        accept;
  logic [7:0]  c;
  logic        is_letter, is_digit, is_alnum;
  scan_state_t begin_state;
  logic        do_begin, do_grow, emit0, emit1;
  logic [3:0]  kind0;
  tok_word_t   tok0, tok1;
  logic [31:0] sp_cur, sp_new, rl_cur, rl_new;

  assign src_stall = queue_full;
  assign accept    = src_valid && !queue_full;
  assign c         = src_data.char_code;
  assign is_letter = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  assign is_digit  = (c >= 8'h30 && c <= 8'h39);
  assign is_alnum  = is_letter || is_digit;

  always_comb begin
    if (is_letter) begin
      begin_state = (c == CH_I) ? S_I1 : S_ID;
    end else if (is_digit) begin
      begin_state = S_LIT;
    end else begin
      unique case (c)
        CH_GT:     begin_state = S_GT;
        CH_PLUS:   begin_state = S_PLUS;
        CH_MINUS:  begin_state = S_MINUS;
        CH_STAR:   begin_state = S_STAR;
        CH_SLASH:  begin_state = S_SLASH;
        CH_SEMI:   begin_state = S_SEMI;
        CH_LPAREN: begin_state = S_LP;
        CH_RPAREN: begin_state = S_RP;
        CH_EQ:     begin_state = S_ASSIGN;
        default:   begin_state = S_INIT;
      endcase
    end
  end

  always_comb begin
    scan_state_next = scan_state;
    do_begin        = 1'b0;
    do_grow         = 1'b0;
    emit0           = 1'b0;
    kind0           = KIND_IDENT;
    unique case (scan_state)
      S_INIT: do_begin = 1'b1;
      S_ID: begin
        if (is_alnum) do_grow = 1'b1;
        else emit0 = 1'b1;
      end
      S_I1, S_I2: begin
        if (c == ((scan_state == S_I1) ? CH_N : CH_T)) begin
          scan_state_next = (scan_state == S_I1) ? S_I2 : S_I3;
          do_grow = 1'b1;
        end else if (is_alnum) begin
          scan_state_next = S_ID;
          do_grow = 1'b1;
        end else begin
          emit0 = 1'b1;
        end
      end
      S_I3: begin
        if (is_alnum) begin
          scan_state_next = S_ID;
          do_grow = 1'b1;
        end else begin
          emit0 = 1'b1;
          kind0 = KIND_INT;
        end
      end
      S_LIT: begin
        if (is_digit) do_grow = 1'b1;
        else begin
          emit0 = 1'b1;
          kind0 = KIND_INTLIT;
        end
      end
      S_GT: begin
        if (c == CH_EQ) begin
          scan_state_next = S_GE;
          do_grow = 1'b1;
        end else begin
          emit0 = 1'b1;
          kind0 = KIND_GT;
        end
      end
      default: begin
        emit0 = 1'b1;
        kind0 = kind_of_state(scan_state);
      end
    endcase
    if (emit0) do_begin = 1'b1;

    start_pos_next  = start_pos;
    run_len_next    = run_len;
    overflowed_next = overflowed;
    if (do_grow) begin
      if (run_len < MAX_TOKEN_LEN[LEN_BITS-1:0]) run_len_next = run_len + LEN_BITS'(1);
      else overflowed_next = 1'b1;
    end
    if (do_begin) begin
      scan_state_next = begin_state;
      if (begin_state != S_INIT) begin
        start_pos_next  = char_pos;
        run_len_next    = LEN_BITS'(1);
        overflowed_next = 1'b0;
      end
    end
    // At end of input whatever is still pending is flushed as a second token.
    emit1 = src_data.end_of_input && (scan_state_next != S_INIT);
  end

  always_comb begin
    sp_cur = 32'(start_pos);
    sp_new = 32'(start_pos_next);
    rl_cur = 32'(run_len);
    rl_new = 32'(run_len_next);

    tok0.token_kind     = kind0;
    tok0.token_start    = sp_cur[15:0];
    tok0.token_length   = rl_cur[7:0];
    tok0.length_clipped = overflowed;
    tok0.run_last       = 1'b0;

    tok1.token_kind     = kind_of_state(scan_state_next);
    tok1.token_start    = sp_new[15:0];
    tok1.token_length   = rl_new[7:0];
    tok1.length_clipped = overflowed_next;
    tok1.run_last       = 1'b0;

    push_data.first      = emit0 ? tok0 : tok1;
    push_data.second     = tok1;
    push_data.has_second = emit0 && emit1;
    push                 = accept && (emit0 || emit1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_state <= S_INIT;
      start_pos  <= '0;
      run_len    <= '0;
      overflowed <= 1'b0;
      char_pos   <= '0;
    end else if (accept) begin
      if (src_data.end_of_input) begin
        scan_state <= S_INIT;
        start_pos  <= '0;
        run_len    <= '0;
        overflowed <= 1'b0;
        char_pos   <= '0;
      end else begin
        scan_state <= scan_state_next;
        start_pos  <= start_pos_next;
        run_len    <= run_len_next;
        overflowed <= overflowed_next;
        char_pos   <= char_pos + POSITION_BITS'(1);
      end
    end
  end

endmodule

### hw/rtl/dlts_queue.sv
// Short queue of token pairs between the scanner front end and the output stage.
// Depends on dlts_pkg for the entry type and depth.
module dlts_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  dlts_pkg::tok_pair_t push_data,
  output logic                full,
  input  logic                pop,
  output logic                nonempty,
  output dlts_pkg::tok_pair_t head
);
  import dlts_pkg::*;

  tok_pair_t            entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QPTR_BITS:0]   count;

  assign full     = (count == (QPTR_BITS + 1)'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign head     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_BITS'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_BITS'(1);
      if (push && !pop)      count <= count + (QPTR_BITS + 1)'(1);
      else if (pop && !push) count <= count - (QPTR_BITS + 1)'(1);
    end
  end

endmodule

### hw/rtl/dlts_back.sv
// Output stage: unpacks token pairs into single words behind an output register.
// Depends on dlts_pkg; reads the head of dlts_queue.
module dlts_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                nonempty,
  input  dlts_pkg::tok_pair_t head,
  output logic                pop,
  output logic                tok_valid,
  input  logic                tok_stall,
  output dlts_pkg::tok_word_t tok_data
);
  import dlts_pkg::*;

  logic      second_sel;
  logic      load;
  tok_word_t tok_data_next;

  // The register can take a new word when it is empty or its word leaves now.
  assign load = nonempty && (!tok_valid || !tok_stall);
  assign pop  = load && (second_sel || !head.has_second);

  always_comb begin
    tok_data_next          = second_sel ? head.second : head.first;
    tok_data_next.run_last = second_sel || !head.has_second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid  <= 1'b0;
      second_sel <= 1'b0;
    end else begin
      if (load) begin
        tok_valid  <= 1'b1;
        second_sel <= !second_sel && head.has_second;
      end else if (!tok_stall) begin
        tok_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tok_data <= tok_data_next;
    end
  end

endmodule

### hw/rtl/dfa_lexer_token_scanner.sv
// DFA token scanner: one character word accepted per cycle, tokens leave one per cycle, while
// neither a full queue nor tok_stall holds the flow; the character rate is set by the DFA step.
// A token passes the front end, queue and output register; an end-of-input flush giving two
// tokens sends the second after the first. A run of two-token words is limited by the
// one-word-per-cycle output register. Synchronous reset clears all but the stored tokens.
module dfa_lexer_token_scanner #(
  parameter int POSITION_BITS = 16,
  parameter int MAX_TOKEN_LEN = 255
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                src_valid,
  output logic                src_stall,
  input  dlts_pkg::src_word_t src_data,
  output logic                tok_valid,
  input  logic                tok_stall,
  output dlts_pkg::tok_word_t tok_data
);
  import dlts_pkg::*;

  logic      push, pop, full, nonempty;
  tok_pair_t push_data, head;

  dlts_front #(
    .POSITION_BITS(POSITION_BITS),
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_data  (src_data),
    .queue_full(full),
    .push      (push),
    .push_data (push_data)
  );

  dlts_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .full     (full),
    .pop      (pop),
    .nonempty (nonempty),
    .head     (head)
  );

  dlts_back u_back (
    .clk      (clk),
    .rst      (rst),
    .nonempty (nonempty),
    .head     (head),
    .pop      (pop),
    .tok_valid(tok_valid),
    .tok_stall(tok_stall),
    .tok_data (tok_data)
  );

endmodule

### tb/sv/dfa_lexer_token_scanner_tb.sv
// Self-checking testbench for the DFA token scanner: feeds character words, predicts tokens.
// Depends on dlts_pkg for the word types, state encoding, token kinds and character codes.
module dfa_lexer_token_scanner_tb;
  import dlts_pkg::*;

  localparam int         LIMIT_CYCLES = 2000000;
  localparam int         MAX_LEN      = 255;
  localparam logic [7:0] CH_BLANK     = 8'h20;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      src_valid = 1'b0;
  logic      src_stall;
  src_word_t src_data = '0;
  logic      tok_valid;
  logic      tok_stall = 1'b0;
  tok_word_t tok_data;

  dfa_lexer_token_scanner dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_data  (src_data),
    .tok_valid (tok_valid),
    .tok_stall (tok_stall),
    .tok_data  (tok_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  src_word_t src_pending[$];
  tok_word_t tok_expected[$];

  int sender_idle = 0;
  int sink_stall  = 0;
  int mismatches  = 0;
  int chars_sent  = 0;
  int tokens_seen = 0;
  int clipped_seen = 0;
  int flushes     = 0;
  int cycle_count = 0;

  // Scanner state as the predictor sees it.
  scan_state_t ps_state = S_INIT;
  logic [15:0] ps_start = '0;
  logic [7:0]  ps_len   = '0;
  logic        ps_over  = 1'b0;
  logic [15:0] ps_pos   = '0;

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alnum(input logic [7:0] c);
    return is_letter(c) || is_digit(c);
  endfunction

  function automatic logic [3:0] state_kind(input scan_state_t s);
    case (s)
      S_I3:     return KIND_INT;
      S_LIT:    return KIND_INTLIT;
      S_GT:     return KIND_GT;
      S_GE:     return KIND_GE;
      S_PLUS:   return KIND_PLUS;
      S_MINUS:  return KIND_MINUS;
      S_STAR:   return KIND_STAR;
      S_SLASH:  return KIND_SLASH;
      S_SEMI:   return KIND_SEMI;
      S_LP:     return KIND_LPAREN;
      S_RP:     return KIND_RPAREN;
      S_ASSIGN: return KIND_ASSIGN;
      default:  return KIND_IDENT;
    endcase
  endfunction

  function automatic tok_word_t pending_token(input logic [3:0] kind);
    tok_word_t t;
    t.token_kind     = kind;
    t.token_start    = ps_start;
    t.token_length   = ps_len;
    t.length_clipped = ps_over;
    t.run_last       = 1'b0;
    return t;
  endfunction

  function automatic void lengthen_token();
    if (ps_len < MAX_LEN) ps_len = ps_len + 8'd1;
    else ps_over = 1'b1;
  endfunction

  function automatic void open_token(input logic [7:0] c);
    scan_state_t s;
    if (is_letter(c)) s = (c == CH_I) ? S_I1 : S_ID;
    else if (is_digit(c)) s = S_LIT;
    else if (c == CH_GT) s = S_GT;
    else if (c == CH_PLUS) s = S_PLUS;
    else if (c == CH_MINUS) s = S_MINUS;
    else if (c == CH_STAR) s = S_STAR;
    else if (c == CH_SLASH) s = S_SLASH;
    else if (c == CH_SEMI) s = S_SEMI;
    else if (c == CH_LPAREN) s = S_LP;
    else if (c == CH_RPAREN) s = S_RP;
    else if (c == CH_EQ) s = S_ASSIGN;
    else s = S_INIT;
    ps_state = s;
    if (s != S_INIT) begin
      ps_start = ps_pos;
      ps_len   = 8'd1;
      ps_over  = 1'b0;
    end
  endfunction

  // Works out the tokens that one accepted character word gives and queues them.
  task automatic scan_char(input src_word_t w);
    logic [7:0] c;
    logic [3:0] kind;
    bit         ends;
    tok_word_t  made[$];
    c    = w.char_code;
    ends = 1'b0;
    kind = KIND_IDENT;
    case (ps_state)
      S_INIT: open_token(c);
      S_ID: begin
        if (is_alnum(c)) lengthen_token();
        else ends = 1'b1;
      end
      S_I1, S_I2: begin
        if (c == ((ps_state == S_I1) ? CH_N : CH_T)) begin
          ps_state = ps_state.next();
          lengthen_token();
        end else if (is_alnum(c)) begin
          ps_state = S_ID;
          lengthen_token();
        end else begin
          ends = 1'b1;
        end
      end
      S_I3: begin
        if (is_alnum(c)) begin
          ps_state = S_ID;
          lengthen_token();
        end else begin
          ends = 1'b1;
          kind = KIND_INT;
        end
      end
      S_LIT: begin
        if (is_digit(c)) lengthen_token();
        else begin
          ends = 1'b1;
          kind = KIND_INTLIT;
        end
      end
      S_GT: begin
        if (c == CH_EQ) begin
          ps_state = S_GE;
          lengthen_token();
        end else begin
          ends = 1'b1;
          kind = KIND_GT;
        end
      end
      default: begin
        ends = 1'b1;
        kind = state_kind(ps_state);
      end
    endcase
    if (ends) begin
      made = {made, pending_token(kind)};
      open_token(c);
    end
    ps_pos = ps_pos + 16'd1;
    if (w.end_of_input) begin
      if (ps_state != S_INIT) made = {made, pending_token(state_kind(ps_state))};
      ps_state = S_INIT;
      ps_start = '0;
      ps_len   = '0;
      ps_over  = 1'b0;
      ps_pos   = '0;
      flushes++;
    end
    if (made.size() > 0) made[made.size() - 1].run_last = 1'b1;
    foreach (made[i]) tok_expected = {tok_expected, made[i]};
  endtask

  // Driver: offers the next pending word, holding it steady while stalled.
  always @(posedge clk) begin
    if (rst) begin
      src_valid <= 1'b0;
    end else begin
      if (src_valid && !src_stall) begin
        scan_char(src_data);
        chars_sent++;
      end
      if (!src_valid || !src_stall) begin
        if (src_pending.size() > 0 && $urandom_range(0, 99) >= sender_idle) begin
          src_valid <= 1'b1;
          src_data  <= src_pending.pop_front();
        end else begin
          src_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stalls at random and checks every accepted token word.
  always @(posedge clk) begin
    tok_word_t want;
    tok_stall <= ($urandom_range(0, 99) < sink_stall);
    if (!rst && tok_valid && !tok_stall) begin
      tokens_seen++;
      if (tok_data.length_clipped) clipped_seen++;
      if (tok_expected.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected token kind %0d start %0d len %0d clip %b last %b", $time,
                 tok_data.token_kind, tok_data.token_start, tok_data.token_length,
                 tok_data.length_clipped, tok_data.run_last);
      end else begin
        want = tok_expected.pop_front();
        if (tok_data.token_kind !== want.token_kind ||
            tok_data.token_start !== want.token_start ||
            tok_data.token_length !== want.token_length ||
            tok_data.length_clipped !== want.length_clipped ||
            tok_data.run_last !== want.run_last) begin
          mismatches++;
          $display("%0t: token mismatch, expected kind %0d start %0d len %0d clip %b last %b",
                   $time, want.token_kind, want.token_start, want.token_length,
                   want.length_clipped, want.run_last);
          $display("%0t:                 actual   kind %0d start %0d len %0d clip %b last %b",
                   $time, tok_data.token_kind, tok_data.token_start, tok_data.token_length,
                   tok_data.length_clipped, tok_data.run_last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("%0t: timed out with %0d tokens outstanding", $time, tok_expected.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic push_char(input logic [7:0] c);
    src_word_t w;
    w.char_code    = c;
    w.end_of_input = 1'b0;
    src_pending = {src_pending, w};
  endtask

  task automatic mark_end();
    src_pending[src_pending.size() - 1].end_of_input = 1'b1;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 1)) return 8'("a" + $urandom_range(0, 25));
    return 8'("A" + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_alnum();
    if ($urandom_range(0, 3) == 0) return rand_digit();
    return rand_letter();
  endfunction

  function automatic logic [7:0] rand_op();
    case ($urandom_range(0, 8))
      0: return CH_PLUS;
      1: return CH_MINUS;
      2: return CH_STAR;
      3: return CH_SLASH;
      4: return CH_SEMI;
      5: return CH_LPAREN;
      6: return CH_RPAREN;
      7: return CH_EQ;
      default: return CH_GT;
    endcase
  endfunction

  // Anything that cannot continue a word token: a blank, an operator or a stray code.
  function automatic logic [7:0] rand_separator();
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0, 1: c = CH_BLANK;
      2: c = rand_op();
      default: begin
        c = 8'($urandom_range(0, 255));
        while (is_alnum(c)) c = 8'($urandom_range(0, 255));
      end
    endcase
    return c;
  endfunction

  // A word token of the given length; digits only for a literal.
  task automatic push_run(input logic [7:0] lead, input int len, input bit digits);
    push_char(lead);
    for (int i = 1; i < len; i++) push_char(digits ? rand_digit() : rand_alnum());
  endtask

  // Mostly well-formed source text with random content, some noise and random stream ends.
  task automatic push_source(input int count, input bit allow_end);
    int first;
    first = src_pending.size();
    while (src_pending.size() - first < count) begin
      case ($urandom_range(0, 99)) inside
        [0:29]: begin
          case ($urandom_range(0, 5))
            0: push_text("i");
            1: push_text("in");
            2: push_text("int");
            default: push_char(rand_letter());
          endcase
          repeat ($urandom_range(0, 6)) push_char(rand_alnum());
        end
        [30:39]: push_text("int");
        [40:54]: push_run(rand_digit(), $urandom_range(1, 6), 1'b1);
        [55:64]: begin
          push_char(CH_GT);
          if ($urandom_range(0, 1)) push_char(CH_EQ);
        end
        [65:84]: push_char(rand_op());
        [85:94]: repeat ($urandom_range(1, 3)) push_char(CH_BLANK);
        default: push_char(8'($urandom_range(0, 255)));
      endcase
      if ($urandom_range(0, 1)) push_char(rand_separator());
      if (allow_end && $urandom_range(0, 29) == 0) mark_end();
    end
    mark_end();
  endtask

  task automatic wait_drained();
    while (src_pending.size() != 0 || src_valid || tok_expected.size() != 0) @(negedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Sender idles rarely, receiver stalls often.
    @(negedge clk);
    sender_idle = 18;
    sink_stall  = 80;
    push_text("int;");          // keyword closed by an operator, which then starts a token
    push_text("in9+");          // keyword prefix turning into an identifier
    push_text(">=>");
    push_text("-*/)=");
    push_char(8'hFF);
    push_char(8'h00);
    push_char(8'h80);
    push_text("int");           // keyword pending at end of input
    mark_end();
    push_text("x(");            // end of input on an operator gives two tokens
    mark_end();
    push_source(300, 1'b1);
    wait_drained();

    // Sender idles often, receiver stalls rarely.
    sender_idle = 80;
    sink_stall  = 18;
    push_source(300, 1'b1);
    wait_drained();

    // No idling: long tokens around the saturation point, then more random source text.
    sender_idle = 0;
    sink_stall  = 0;
    push_run(rand_letter(), 255, 1'b0);
    push_char(CH_BLANK);
    push_run(rand_letter(), 256, 1'b0);
    push_char(CH_SEMI);
    push_run(rand_digit(), 280, 1'b1);
    push_char(CH_BLANK);
    push_text("int");
    push_run(rand_alnum(), 260, 1'b0);
    mark_end();
    push_source(120, 1'b1);
    wait_drained();
    repeat (10) @(posedge clk);

    $display("Sent %0d characters with %0d end-of-input flushes; checked %0d tokens,",
             chars_sent, flushes, tokens_seen);
    $display("%0d of them clipped, with %0d mismatching.", clipped_seen, mismatches);
    if (mismatches == 0 && tok_expected.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
